// ----- rtl/core/rgb_to_hsv_convert_top_assert.svh -----
// Assertion macros for the file that checks this block.
// Each macro takes a label, a trigger, a consequence and a message.
`ifndef RGB_TO_HSV_CONVERT_TOP_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_TOP_ASSERT_SVH

// The consequence must hold in the same cycle as the trigger.
`define RHC_ASSERT_SAME(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define RHC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rhc_pkg.sv -----
package rhc_pkg;

  // Depth of the queue between the classifying front and the divider back end.
  localparam int unsigned QueueDepth = 2;

  // Quotient widths of the two divisions: hue magnitude up to 3840, saturation up to 255.
  localparam int unsigned HueQw = 12;
  localparam int unsigned SatQw = 8;

  // Dividend widths: 3840 * 255 needs 20 bits, 255 * 255 needs 16 bits.
  localparam int unsigned HueNumW = 20;
  localparam int unsigned SatNumW = 16;

  // Hue is carried in 1/64 degree: 3840 units per 60 degree sector.
  localparam logic [15:0] HueSector = 16'd3840;
  localparam logic [15:0] HueFull   = 16'd23040;

  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_e;

  // One classified pixel as it leaves the front and waits in the queue.
  typedef struct packed {
    logic [7:0]         val;
    logic [7:0]         delta;
    logic [HueNumW-1:0] hnum;
    sector_e            sector;
    logic               neg;
  } job_t;

  // State of one pixel inside the divider pipeline.
  typedef struct packed {
    logic [HueNumW-1:0] hrem;
    logic [SatNumW-1:0] srem;
    logic [HueQw-1:0]   hq;
    logic [SatQw-1:0]   sq;
    logic [7:0]         val;
    logic [7:0]         delta;
    sector_e            sector;
    logic               neg;
  } div_stage_t;

endpackage

// ----- rtl/core/rhc_front.sv -----
module rhc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output rhc_pkg::job_t    job_o
);

  logic [7:0]       rg_max, rg_min, mx, mn, pos, ngv, diff;
  rhc_pkg::sector_e sector;
  rhc_pkg::job_t    job_d, job_q;
  logic             valid_d, valid_q;

  // Largest and smallest channel, then the dominant channel picks the sector.
  always_comb begin
    rg_max = (red_i >= green_i) ? red_i : green_i;
    rg_min = (red_i <= green_i) ? red_i : green_i;
    mx     = (rg_max >= blue_i) ? rg_max : blue_i;
    mn     = (rg_min <= blue_i) ? rg_min : blue_i;

    priority if (red_i == mx) begin
      sector = rhc_pkg::SEC_RED;
      pos    = green_i;
      ngv    = blue_i;
    end else if (green_i == mx) begin
      sector = rhc_pkg::SEC_GREEN;
      pos    = blue_i;
      ngv    = red_i;
    end else begin
      sector = rhc_pkg::SEC_BLUE;
      pos    = red_i;
      ngv    = green_i;
    end

    diff = (pos >= ngv) ? (pos - ngv) : (ngv - pos);

    job_d.val    = mx;
    job_d.delta  = mx - mn;
    job_d.sector = sector;
    job_d.neg    = (pos < ngv);
    // 3840 * diff written as 4096 * diff - 256 * diff.
    job_d.hnum   = (rhc_pkg::HueNumW'(diff) << 12) - (rhc_pkg::HueNumW'(diff) << 8);
  end

  assign in_ready_o  = !valid_q || job_ready_i;
  assign valid_d     = in_ready_o ? in_valid_i : valid_q;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

endmodule

// ----- rtl/core/rhc_queue.sv -----
module rhc_queue #(
  parameter int unsigned DEPTH = rhc_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          ready_o,
  input  rhc_pkg::job_t data_i,
  output logic          valid_o,
  input  logic          pop_i,
  output rhc_pkg::job_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rhc_pkg::job_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] count_d, count_q;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/rhc_back.sv -----
module rhc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_pop_o,
  input  rhc_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [14:0]   hue_o,
  output logic [7:0]    saturation_o,
  output logic [7:0]    brightness_o
);

  localparam int unsigned NStg = rhc_pkg::HueQw;

  rhc_pkg::div_stage_t stg_q [NStg+1];
  logic [NStg:0]       stg_v_q;
  logic                advance;

  rhc_pkg::div_stage_t fin;
  logic [rhc_pkg::HueQw-1:0] hmag;
  logic [8:0]                sat_r;
  logic [15:0]               base, hue_w;
  logic [14:0]               hue_d, hue_q;
  logic [7:0]                sat_d, sat_q, bri_q;
  logic                      out_v_q;

  // The whole pipeline moves together whenever the output register can take an item.
  assign advance   = !out_v_q || out_ready_i;
  assign job_pop_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
    end else if (advance) begin
      stg_v_q <= {stg_v_q[NStg-1:0], job_valid_i};
    end
  end

  // Stage zero loads the dividends; each later stage settles one quotient bit.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      stg_q[0].hrem   <= job_i.hnum;
      stg_q[0].srem   <= (rhc_pkg::SatNumW'(job_i.delta) << 8)
                         - rhc_pkg::SatNumW'(job_i.delta);
      stg_q[0].hq     <= '0;
      stg_q[0].sq     <= '0;
      stg_q[0].val    <= job_i.val;
      stg_q[0].delta  <= job_i.delta;
      stg_q[0].sector <= job_i.sector;
      stg_q[0].neg    <= job_i.neg;
    end
  end

  for (genvar k = 1; k <= NStg; k++) begin : g_div
    localparam int unsigned Bi = NStg - k;
    rhc_pkg::div_stage_t nxt;
    logic [rhc_pkg::HueNumW-1:0] hcmp;

    always_comb begin
      nxt  = stg_q[k-1];
      hcmp = rhc_pkg::HueNumW'(stg_q[k-1].delta) << Bi;
      if (stg_q[k-1].hrem >= hcmp) begin
        nxt.hrem   = stg_q[k-1].hrem - hcmp;
        nxt.hq[Bi] = 1'b1;
      end
    end

    if (Bi < rhc_pkg::SatQw) begin : g_sat
      logic [rhc_pkg::SatNumW-1:0] scmp;
      rhc_pkg::div_stage_t         nxt_s;
      always_comb begin
        nxt_s = nxt;
        scmp  = rhc_pkg::SatNumW'(stg_q[k-1].val) << Bi;
        if (stg_q[k-1].srem >= scmp) begin
          nxt_s.srem   = stg_q[k-1].srem - scmp;
          nxt_s.sq[Bi] = 1'b1;
        end
      end
      always_ff @(posedge clk_i) begin
        if (advance) begin
          stg_q[k] <= nxt_s;
        end
      end
    end else begin : g_hue_only
      always_ff @(posedge clk_i) begin
        if (advance) begin
          stg_q[k] <= nxt;
        end
      end
    end
  end

  // Round to nearest from the remainder, then place the magnitude in its sector.
  always_comb begin
    fin   = stg_q[NStg];
    hmag  = fin.hq + rhc_pkg::HueQw'({fin.hrem[7:0], 1'b0} >= {1'b0, fin.delta});
    sat_r = {1'b0, fin.sq} + 9'({fin.srem[7:0], 1'b0} >= {1'b0, fin.val});

    unique case (fin.sector)
      rhc_pkg::SEC_RED:   base = '0;
      rhc_pkg::SEC_GREEN: base = rhc_pkg::HueSector << 1;
      rhc_pkg::SEC_BLUE:  base = rhc_pkg::HueSector << 2;
      default:            base = '0;
    endcase

    if (!fin.neg) begin
      hue_w = base + 16'(hmag);
    end else if (16'(hmag) > base) begin
      hue_w = base + rhc_pkg::HueFull - 16'(hmag);
    end else begin
      hue_w = base - 16'(hmag);
    end
    if (hue_w >= rhc_pkg::HueFull) begin
      hue_w = hue_w - rhc_pkg::HueFull;
    end

    hue_d = (fin.delta == '0) ? '0 : hue_w[14:0];
    sat_d = (fin.val == '0) ? '0 : sat_r[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= stg_v_q[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stg_v_q[NStg]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= fin.val;
    end
  end

  assign out_valid_o  = out_v_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bri_q;

endmodule

// ----- rtl/core/rgb_to_hsv_convert_top.sv -----
// RGB to HSV converter: takes one 8-bit RGB pixel per item and returns hue in 1/64 degree
// (0 to 23039), saturation scaled to 255 and value (the largest channel). The block
// accepts one pixel every clock cycle while the output is not held; that throughput is
// kept by the twelve-stage pipelined divider in the back end, which settles one quotient
// bit per stage for hue and, over its last eight stages, for saturation alongside it. A
// register stage at the input classifies each pixel (maximum, minimum, dominant channel,
// channel difference) and hands it through a short queue to the back end, so that the
// input side keeps taking pixels while a result waits at the output, until the queue and
// the input register fill. Grey pixels give a hue of zero and black pixels a saturation
// of zero. There is no configuration and no state between pixels.
module rgb_to_hsv_convert_top #(
  parameter int unsigned QUEUE_DEPTH = rhc_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [14:0] hue, [22:15] saturation, [30:23] brightness,
                                      // [31] zero
);

  rhc_pkg::job_t front_job, queue_job;
  logic          front_valid, queue_ready, queue_valid, back_pop;
  logic [14:0]   hue;
  logic [7:0]    saturation, brightness;

  // The front computes the channel extremes and picks the hue sector for each item.
  rhc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .red_i       (s_axis_tdata[7:0]),
    .green_i     (s_axis_tdata[15:8]),
    .blue_i      (s_axis_tdata[23:16]),
    .job_valid_o (front_valid),
    .job_ready_i (queue_ready),
    .job_o       (front_job)
  );

  // The queue lets the front keep accepting items while the back end is held.
  rhc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (queue_ready),
    .data_i  (front_job),
    .valid_o (queue_valid),
    .pop_i   (back_pop),
    .data_o  (queue_job)
  );

  // The back end divides, rounds, wraps the hue and holds the result for the output.
  rhc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (queue_valid),
    .job_pop_o    (back_pop),
    .job_i        (queue_job),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .hue_o        (hue),
    .saturation_o (saturation),
    .brightness_o (brightness)
  );

  assign m_axis_tdata = {1'b0, brightness, saturation, hue};

  `include "rgb_to_hsv_convert_top_assert.svh"

  // Hue always stays below a full turn.
  `RHC_ASSERT_SAME(a_hue_range, m_axis_tvalid, hue < 15'd23040, "hue out of range")
  // A black pixel has no saturation.
  `RHC_ASSERT_SAME(a_black_sat, m_axis_tvalid && (brightness == '0), saturation == '0,
    "black pixel with saturation")
  // Zero saturation only arises from a grey pixel, whose hue is zero.
  `RHC_ASSERT_SAME(a_grey_hue, m_axis_tvalid && (saturation == '0), hue == '0,
    "grey pixel with hue")

endmodule
